// ----- src/awu_pkg.sv -----
// ----------------------------------------------------------------------------
// awu_pkg: shared types and constants of the Adam weight update block
// Register map, reset values, sequencer states, multiplier operations and
// the widths of the iterative arithmetic units.
// ----------------------------------------------------------------------------
package awu_pkg;

	localparam int NUM_PARAMS_DEF = 4096;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Field widths
	localparam int IDX_W   = 12;
	localparam int Q_W     = 32;
	localparam int V_W     = 48;
	localparam int BETA_W  = 31;
	localparam int EPS_W   = 24;

	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

	// Register reset values
	localparam logic [30:0] LR_RESET   = 31'd2147484;
	localparam logic [30:0] B1_RESET   = 31'd1932735283;
	localparam logic [30:0] B2_RESET   = 31'd2145336164;
	localparam logic [23:0] EPS_RESET  = 24'd1;

	// Iterative units. The index reduction takes a reciprocal multiply,
	// a subtract of the estimated multiple and one correcting subtract.
	localparam int MOD_STEPS  = 3;
	localparam int DIV_NUM_W  = 95;
	localparam int DIV_DEN_W  = 33;
	localparam int DIV_STEPS  = 95;
	localparam int SQRT_STEPS = 32;
	localparam int CNT_W      = 7;

	// Largest step magnitude that is applied to a weight
	localparam logic [33:0] STEP_MAX = 34'h2_0000_0000;

	typedef enum logic [1:0] {
		REG_LEARNING_RATE,
		REG_FIRST_DECAY,
		REG_SECOND_DECAY,
		REG_STABILITY_TERM
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_MUL,
		ST_DIV_M,
		ST_DIV_V,
		ST_SQRT,
		ST_DIV_R,
		ST_OUT
	} state_t;

	// Multiplications issued by the sequencer, in order
	typedef enum logic [3:0] {
		OP_P1,
		OP_P2,
		OP_M1,
		OP_M2,
		OP_SQ,
		OP_V1,
		OP_V2,
		OP_V3,
		OP_V4,
		OP_VW,
		OP_R1,
		OP_R2,
		OP_RD
	} mul_op_t;

endpackage

// ----- src/adam_weight_update.sv -----
// ----------------------------------------------------------------------------
// adam_weight_update: Adam optimizer step for one parameter per word
// Steps per word: 3 index reduction, 1 read, 13 multiply, three 95-step
// divides and 32 root steps; the last divide is skipped when the root
// plus epsilon is zero. The bit-serial divider and root unit are shared,
// so a new word is taken only once the last one has gone to the output
// register. After reset every address of the moment memories is cleared
// before the first word is taken.
// ----------------------------------------------------------------------------
module adam_weight_update #(
	parameter int NUM_PARAMS = awu_pkg::NUM_PARAMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [awu_pkg::PADDR_W-1:0] paddr,
	input  logic [awu_pkg::PDATA_W-1:0] pwdata,
	output logic [awu_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	// Input words
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        new_step,
	input  logic [awu_pkg::IDX_W-1:0]   param_index,
	input  logic signed [31:0]          gradient,
	input  logic signed [31:0]          weight_in,
	// Result words
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          weight_out,
	output logic                        clipped
);

	import awu_pkg::*;

	// The moment stores are addressed with just enough bits for NUM_PARAMS.
	localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PARAMS - 1);
	localparam logic [32:0] NP_W = 33'(NUM_PARAMS);
	// Reciprocal of NUM_PARAMS scaled by 2^24 for the index reduction.
	localparam logic [24:0] MOD_RECIP = 25'((1 << 24) / NUM_PARAMS);

	// ------------------------------------------------------------------
	// Configuration registers. pready is tied high, so a write lands in
	// the access cycle. The two low address bits are not decoded.
	// ------------------------------------------------------------------
	logic [30:0] lr_q;
	logic [30:0] b1_q;
	logic [30:0] b2_q;
	logic [23:0] eps_q;
	logic        cfg_we;
	reg_idx_t    cfg_sel;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign cfg_sel = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_sel)
			REG_LEARNING_RATE:  prdata = {1'b0, lr_q};
			REG_FIRST_DECAY:    prdata = {1'b0, b1_q};
			REG_SECOND_DECAY:   prdata = {1'b0, b2_q};
			REG_STABILITY_TERM: prdata = {8'b0, eps_q};
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer state
	// ------------------------------------------------------------------
	state_t           state_q, state_d;
	mul_op_t          op_q, op_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [AW-1:0]    clr_addr_q;
	logic             out_valid_q;
	logic             load_out;
	logic [31:0]      p1_q, p2_q;

	// Datapath registers
	logic             ns_q;
	logic [11:0]      idx_q;
	logic [11:0]      modq_q;
	logic signed [31:0] g_q, w_q;
	logic signed [65:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] m_q;
	logic [46:0]      g2_q;
	logic [50:0]      vacc_q;
	logic [47:0]      v_q;
	logic [63:0]      mhat_q;
	logic [63:0]      ratio_q;
	logic [31:0]      tacc_q;
	logic [31:0]      wres_q;
	logic             wclip_q;
	logic [31:0]      weight_out_q;
	logic             clipped_q;

	// Shared divider and root unit
	logic [DIV_NUM_W-1:0] dnum_q;
	logic [DIV_DEN_W-1:0] dden_q;
	logic [DIV_DEN_W-1:0] drem_q;
	logic [63:0]          dquo_q;
	logic                 dsat_q;
	logic [63:0]          sx_q;
	logic [33:0]          srem_q;
	logic [31:0]          sroot_q;

	// Memory ports
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   m_wdata, m_rdata;
	logic [47:0]   v_wdata, v_rdata;

	// ------------------------------------------------------------------
	// Shared 33x33 signed multiplier. Unsigned operands are zero
	// extended; the product is registered before anything uses it.
	// ------------------------------------------------------------------
	logic signed [32:0] mul_a, mul_b;
	logic [31:0]        omb1, omb2;
	logic [31:0]        gmag;

	assign omb1 = ONE_Q31 - {1'b0, b1_q};
	assign omb2 = ONE_Q31 - {1'b0, b2_q};
	assign gmag = g_q[31] ? 32'(-g_q) : 32'(g_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op_q)
			OP_P1: begin
				mul_a = {2'b0, b1_q};
				mul_b = {1'b0, p1_q};
			end
			OP_P2: begin
				mul_a = {2'b0, b2_q};
				mul_b = {1'b0, p2_q};
			end
			OP_M1: begin
				mul_a = {2'b0, b1_q};
				mul_b = {m_rdata[31], m_rdata};
			end
			OP_M2: begin
				mul_a = {1'b0, omb1};
				mul_b = {g_q[31], g_q};
			end
			OP_SQ: begin
				mul_a = {1'b0, gmag};
				mul_b = {1'b0, gmag};
			end
			OP_V1: begin
				mul_a = {2'b0, b2_q};
				mul_b = {1'b0, v_rdata[31:0]};
			end
			OP_V2: begin
				mul_a = {2'b0, b2_q};
				mul_b = {17'b0, v_rdata[47:32]};
			end
			OP_V3: begin
				mul_a = {1'b0, omb2};
				mul_b = {1'b0, g2_q[31:0]};
			end
			OP_V4: begin
				mul_a = {1'b0, omb2};
				mul_b = {18'b0, g2_q[46:32]};
			end
			OP_R1: begin
				mul_a = {2'b0, lr_q};
				mul_b = {1'b0, ratio_q[31:0]};
			end
			OP_R2: begin
				mul_a = {2'b0, lr_q};
				mul_b = {1'b0, ratio_q[63:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Combinational helpers for the sequencer steps
	// ------------------------------------------------------------------
	logic signed [63:0] m_sum;
	logic [50:0]        v_sum;
	logic [31:0]        d1, d2;
	logic [31:0]        mmag;

	assign m_sum = acc_q + prod_q[63:0];
	assign v_sum = vacc_q + {2'b0, prod_q[47:0], 1'b0};
	// When the power is still one the bias correction is skipped.
	assign d1    = (p1_q >= ONE_Q31) ? ONE_Q31 : ONE_Q31 - p1_q;
	assign d2    = (p2_q >= ONE_Q31) ? ONE_Q31 : ONE_Q31 - p2_q;
	assign mmag  = m_q[31] ? 32'(-m_q) : 32'(m_q);

	// Index reduction by reciprocal multiplication. The quotient estimate
	// is at most one short, so one compare and subtract finishes it.
	logic [35:0] mod_prod;
	logic [32:0] mod_sub;

	assign mod_prod = {24'b0, idx_q} * {11'b0, MOD_RECIP};
	assign mod_sub  = {21'b0, modq_q} * NP_W;

	// Restoring divider, one quotient bit per cycle. Bits that leave the
	// top of the 64-bit quotient turn the result into all ones.
	logic [DIV_DEN_W:0]   d_trial, d_diff;
	logic                 d_ge;
	logic [DIV_DEN_W-1:0] d_rem_nx;
	logic [63:0]          d_quo_nx;
	logic                 d_sat_nx;
	logic [63:0]          d_res;

	assign d_trial  = {drem_q, dnum_q[DIV_NUM_W-1]};
	assign d_ge     = d_trial >= {1'b0, dden_q};
	assign d_diff   = d_trial - {1'b0, dden_q};
	assign d_rem_nx = d_ge ? d_diff[DIV_DEN_W-1:0] : d_trial[DIV_DEN_W-1:0];
	assign d_quo_nx = {dquo_q[62:0], d_ge};
	assign d_sat_nx = dsat_q | dquo_q[63];
	assign d_res    = d_sat_nx ? '1 : d_quo_nx;

	// Integer square root, two radicand bits per cycle.
	logic [35:0] s_trial, s_cmp, s_diff;
	logic        s_ge;
	logic [33:0] s_rem_nx;
	logic [31:0] s_root_nx;
	logic [32:0] den_sum;

	assign s_trial   = {srem_q, sx_q[63:62]};
	assign s_cmp     = {2'b0, sroot_q, 2'b01};
	assign s_ge      = s_trial >= s_cmp;
	assign s_diff    = s_trial - s_cmp;
	assign s_rem_nx  = s_ge ? s_diff[33:0] : s_trial[33:0];
	assign s_root_nx = {sroot_q[30:0], s_ge};
	assign den_sum   = {1'b0, s_root_nx} + {9'b0, eps_q};

	// Final step and saturation of the weight.
	logic [63:0]        step_full;
	logic [33:0]        step_cl;
	logic signed [35:0] w_ext, res_w;
	logic [31:0]        res_sat;
	logic               res_clip;

	assign step_full = 64'(tacc_q) + {prod_q[62:0], 1'b0};
	assign step_cl   = (step_full > 64'(STEP_MAX)) ? STEP_MAX : step_full[33:0];
	assign w_ext     = {{4{w_q[31]}}, w_q};
	assign res_w     = m_q[31] ? w_ext + $signed({2'b0, step_cl})
	                           : w_ext - $signed({2'b0, step_cl});

	always_comb begin
		res_clip = 1'b0;
		res_sat  = res_w[31:0];
		if (!res_w[35] && (res_w[35:31] != 5'b0)) begin
			res_sat  = 32'h7FFF_FFFF;
			res_clip = 1'b1;
		end else if (res_w[35] && (res_w[35:31] != 5'b11111)) begin
			res_sat  = 32'h8000_0000;
			res_clip = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Next state and control outputs
	// ------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		cnt_d     = cnt_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		load_out  = 1'b0;
		mem_waddr = AW'(idx_q);
		mem_raddr = AW'(idx_q);
		m_wdata   = m_q;
		v_wdata   = v_sum[47:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				m_wdata   = '0;
				v_wdata   = '0;
				if (clr_addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MOD;
					cnt_d   = '0;
				end
			end
			ST_MOD: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				mem_re  = 1'b1;
				state_d = ST_MUL;
				op_d    = OP_P1;
			end
			ST_MUL: begin
				unique case (op_q)
					OP_P1: op_d = OP_P2;
					OP_P2: op_d = OP_M1;
					OP_M1: op_d = OP_M2;
					OP_M2: op_d = OP_SQ;
					OP_SQ: op_d = OP_V1;
					OP_V1: op_d = OP_V2;
					OP_V2: op_d = OP_V3;
					OP_V3: op_d = OP_V4;
					OP_V4: op_d = OP_VW;
					OP_VW: begin
						mem_we  = 1'b1;
						state_d = ST_DIV_M;
						cnt_d   = '0;
					end
					OP_R1: op_d = OP_R2;
					OP_R2: op_d = OP_RD;
					OP_RD: state_d = ST_OUT;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DIV_M: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_DIV_V;
					cnt_d   = '0;
				end
			end
			ST_DIV_V: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_SQRT;
					cnt_d   = '0;
				end
			end
			ST_SQRT: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					cnt_d = '0;
					if (den_sum == '0) begin
						state_d = ST_MUL;
						op_d    = OP_R1;
					end else begin
						state_d = ST_DIV_R;
					end
				end
			end
			ST_DIV_R: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_MUL;
					op_d    = OP_R1;
					cnt_d   = '0;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers, configuration and decay powers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= OP_P1;
			cnt_q       <= '0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			lr_q        <= LR_RESET;
			b1_q        <= B1_RESET;
			b2_q        <= B2_RESET;
			eps_q       <= EPS_RESET;
			p1_q        <= ONE_Q31;
			p2_q        <= ONE_Q31;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_sel)
					REG_LEARNING_RATE:  lr_q  <= pwdata[30:0];
					REG_FIRST_DECAY:    b1_q  <= pwdata[30:0];
					REG_SECOND_DECAY:   b2_q  <= pwdata[30:0];
					REG_STABILITY_TERM: eps_q <= pwdata[23:0];
					default: ;
				endcase
			end
			// The powers advance only for a word that opens a new step.
			if (state_q == ST_MUL && ns_q) begin
				if (op_q == OP_P2) begin
					p1_q <= prod_q[62:31];
				end
				if (op_q == OP_M1) begin
					p2_q <= prod_q[62:31];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				ns_q  <= new_step;
				idx_q <= param_index;
				g_q   <= gradient;
				w_q   <= weight_in;
			end
			ST_MOD: begin
				if (cnt_q == '0) begin
					modq_q <= mod_prod[35:24];
				end else if (cnt_q == CNT_W'(1)) begin
					idx_q <= idx_q - mod_sub[11:0];
				end else if ({21'b0, idx_q} >= NP_W) begin
					idx_q <= idx_q - NP_W[11:0];
				end
			end
			ST_MUL: begin
				unique case (op_q)
					OP_M2: acc_q <= prod_q[63:0];
					// m is a convex blend of two Q8.24 values, so 32 bits hold it.
					OP_SQ: m_q   <= m_sum[62:31];
					OP_V1: g2_q  <= prod_q[62:16];
					OP_V2: vacc_q <= 51'(prod_q[62:31]);
					OP_V3: vacc_q <= vacc_q + {2'b0, prod_q[47:0], 1'b0};
					OP_V4: vacc_q <= vacc_q + 51'(prod_q[62:31]);
					OP_VW: begin
						v_q    <= v_sum[47:0];
						dnum_q <= {32'b0, mmag, 31'b0};
						dden_q <= {1'b0, d1};
						drem_q <= '0;
						dquo_q <= '0;
						dsat_q <= 1'b0;
					end
					OP_R2: tacc_q <= prod_q[62:31];
					OP_RD: begin
						wres_q  <= res_sat;
						wclip_q <= res_clip;
					end
					default: ;
				endcase
			end
			ST_DIV_M, ST_DIV_V, ST_DIV_R: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					drem_q <= '0;
					dquo_q <= '0;
					dsat_q <= 1'b0;
					if (state_q == ST_DIV_M) begin
						mhat_q <= d_res;
						dnum_q <= {v_q, 47'b0};
						dden_q <= {1'b0, d2};
					end else if (state_q == ST_DIV_V) begin
						sx_q    <= d_res;
						srem_q  <= '0;
						sroot_q <= '0;
					end else begin
						ratio_q <= d_res;
					end
				end else begin
					dnum_q <= {dnum_q[DIV_NUM_W-2:0], 1'b0};
					drem_q <= d_rem_nx;
					dquo_q <= d_quo_nx;
					dsat_q <= d_sat_nx;
				end
			end
			ST_SQRT: begin
				sx_q    <= {sx_q[61:0], 2'b0};
				srem_q  <= s_rem_nx;
				sroot_q <= s_root_nx;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					// A zero denominator yields a zero step.
					ratio_q <= '0;
					dnum_q  <= {7'b0, mhat_q, 24'b0};
					dden_q  <= den_sum;
				end
			end
			default: ;
		endcase
		if (load_out) begin
			weight_out_q <= wres_q;
			clipped_q    <= wclip_q;
		end
	end

	// ------------------------------------------------------------------
	// Moment stores: first moment Q8.24, second moment unsigned Q16.32.
	// Each word is read once and written back before the next is read.
	// ------------------------------------------------------------------
	awu_ram #(
		.WIDTH(Q_W),
		.DEPTH(NUM_PARAMS)
	) u_first_moment (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(m_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(m_rdata)
	);

	awu_ram #(
		.WIDTH(V_W),
		.DEPTH(NUM_PARAMS)
	) u_second_moment (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(v_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(v_rdata)
	);

	assign out_valid  = out_valid_q;
	assign weight_out = weight_out_q;
	assign clipped    = clipped_q;

endmodule

// ----- src/awu_ram.sv -----
// ----------------------------------------------------------------------------
// awu_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module awu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
